[hdl/i2cm_pkg.sv]
`default_nettype none

package i2cm_pkg;

   localparam int unsigned TickCounterBits = 16;
   localparam logic [15:0] PhaseTicksReset = 16'd25;
   localparam logic [3:0]  BitsPerByte     = 4'd8;

   typedef enum logic [2:0] {
      MODE_START  = 3'd0,
      MODE_STOP   = 3'd1,
      MODE_WRITE  = 3'd2,
      MODE_READ   = 3'd3,
      MODE_ACK    = 3'd4,
      MODE_NACK   = 3'd5,
      MODE_GETACK = 3'd6,
      MODE_ADDR   = 3'd7
   } mode_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] mode;
      logic [7:0] data_byte;
      logic       write_request;
      logic       sda_in;
   } req_payload_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_seen;
   } rsp_payload_type;

endpackage

`default_nettype wire

[hdl/i2cm_chan_if.sv]
`default_nettype none

interface i2cm_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hdl/i2cm_seq_core.sv]
`default_nettype none

module i2cm_seq_core #(
   parameter int unsigned TICK_COUNTER_BITS = i2cm_pkg::TickCounterBits
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  i2cm_pkg::req_payload_type req_data,
   input  logic                      csr_wr_en,
   input  logic [15:0]               csr_wr_data,
   output i2cm_pkg::rsp_payload_type rsp_data
);
   import i2cm_pkg::*;

   localparam int unsigned CmpBits = (TICK_COUNTER_BITS > 16) ? TICK_COUNTER_BITS : 16;

   typedef struct packed {
      mode_type                     active_command;
      logic                         busy_flag;
      logic [2:0]                   phase_index;
      logic [3:0]                   bit_index;
      logic [7:0]                   shift_byte;
      logic [TICK_COUNTER_BITS-1:0] tick_count;
      logic                         scl_reg;
      logic                         sda_reg;
      logic                         sda_drive_reg;
      logic                         ack_reg;
      logic                         address_phase;
      logic [7:0]                   read_hold;
   } seq_state_type;

   localparam seq_state_type StateReset = '{
      active_command: MODE_START,
      busy_flag:      1'b0,
      phase_index:    3'd0,
      bit_index:      4'd0,
      shift_byte:     8'd0,
      tick_count:     '0,
      scl_reg:        1'b1,
      sda_reg:        1'b1,
      sda_drive_reg:  1'b1,
      ack_reg:        1'b0,
      address_phase:  1'b0,
      read_hold:      8'd0
   };

   seq_state_type state_ff, state_in;
   logic [15:0]   phase_ticks_ff;
   logic          done_flag;
   mode_type      adv_kind;
   logic [15:0]   lim_short;
   logic [CmpBits-1:0] lim_wide, max_wide, limit, tick_wide;

   function automatic mode_type kind_now(seq_state_type s);
      if (s.active_command == MODE_ADDR) begin
         return s.address_phase ? MODE_WRITE : MODE_START;
      end
      return s.active_command;
   endfunction

   function automatic logic is_last(seq_state_type s, mode_type k);
      logic last;
      case (k)
         MODE_WRITE, MODE_READ: last = (s.bit_index >= BitsPerByte);
         MODE_GETACK:           last = (s.phase_index >= 3'd2);
         default:               last = (s.phase_index >= 3'd3);
      endcase
      return last;
   endfunction

   function automatic seq_state_type enter_phase(seq_state_type s);
      seq_state_type r;
      mode_type      k;
      r = s;
      k = kind_now(s);
      unique case (k)
         MODE_START: begin
            unique case (s.phase_index)
               3'd0: begin
                  r.sda_reg       = 1'b1;
                  r.sda_drive_reg = 1'b1;
               end
               3'd1: r.scl_reg = 1'b1;
               3'd2: r.sda_reg = 1'b0;
               default: r.scl_reg = 1'b0;
            endcase
         end
         MODE_STOP: begin
            unique case (s.phase_index)
               3'd0: begin
                  r.scl_reg       = 1'b0;
                  r.sda_drive_reg = 1'b1;
               end
               3'd1: r.sda_reg = 1'b0;
               3'd2: r.scl_reg = 1'b1;
               default: r.sda_reg = 1'b1;
            endcase
         end
         MODE_WRITE: begin
            if (s.bit_index >= BitsPerByte) begin
               r.scl_reg = 1'b0;
            end else if (s.phase_index == 3'd0) begin
               r.scl_reg = 1'b0;
            end else if (s.phase_index == 3'd1) begin
               r.sda_reg       = s.shift_byte[7];
               r.sda_drive_reg = 1'b1;
            end else begin
               r.scl_reg = 1'b1;
            end
         end
         MODE_READ: begin
            if (s.bit_index >= BitsPerByte) begin
               r.scl_reg       = 1'b0;
               r.sda_drive_reg = 1'b1;
               r.read_hold     = s.shift_byte;
            end else if (s.phase_index == 3'd0) begin
               r.scl_reg       = 1'b0;
               r.sda_drive_reg = 1'b0;
            end else if (s.phase_index == 3'd1) begin
               r.scl_reg = 1'b1;
            end
         end
         MODE_ACK, MODE_NACK: begin
            unique case (s.phase_index)
               3'd0: r.scl_reg = 1'b0;
               3'd1: begin
                  r.sda_reg       = (k == MODE_NACK);
                  r.sda_drive_reg = 1'b1;
               end
               3'd2: r.scl_reg = 1'b1;
               default: r.scl_reg = 1'b0;
            endcase
         end
         default: begin
            if (s.phase_index == 3'd0) begin
               r.scl_reg       = 1'b0;
               r.sda_drive_reg = 1'b0;
            end else if (s.phase_index == 3'd1) begin
               r.scl_reg = 1'b1;
            end else begin
               r.scl_reg       = 1'b0;
               r.sda_drive_reg = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   assign lim_short = (phase_ticks_ff == 16'd0) ? 16'd1 : phase_ticks_ff;
   assign lim_wide  = CmpBits'(lim_short);
   assign max_wide  = (CmpBits'(1) << TICK_COUNTER_BITS) - CmpBits'(1);
   assign limit     = (lim_wide > max_wide) ? max_wide : lim_wide;
   assign tick_wide = CmpBits'(state_ff.tick_count);
   assign adv_kind  = kind_now(state_ff);

   always_comb begin
      state_in  = state_ff;
      done_flag = 1'b0;
      if (state_ff.busy_flag) begin
         if (tick_wide >= limit) begin
            state_in.tick_count = TICK_COUNTER_BITS'(1);
            if (is_last(state_ff, adv_kind)) begin
               if (state_ff.active_command == MODE_ADDR && !state_ff.address_phase) begin
                  state_in.address_phase = 1'b1;
                  state_in.phase_index   = 3'd0;
                  state_in.bit_index     = 4'd0;
                  state_in = enter_phase(state_in);
               end else begin
                  state_in.busy_flag  = 1'b0;
                  state_in.tick_count = '0;
                  done_flag = 1'b1;
               end
            end else begin
               if (adv_kind == MODE_READ && state_ff.phase_index == 3'd1) begin
                  state_in.shift_byte = {state_ff.shift_byte[6:0], req_data.sda_in};
               end
               if (adv_kind == MODE_GETACK && state_ff.phase_index == 3'd1) begin
                  state_in.ack_reg = ~req_data.sda_in;
               end
               if (adv_kind == MODE_WRITE && state_ff.phase_index == 3'd2) begin
                  state_in.shift_byte = {state_ff.shift_byte[6:0], 1'b0};
               end
               state_in.phase_index = state_ff.phase_index + 3'd1;
               if ((adv_kind == MODE_WRITE || adv_kind == MODE_READ)
                   && state_in.phase_index >= 3'd3) begin
                  state_in.phase_index = 3'd0;
                  state_in.bit_index   = state_ff.bit_index + 4'd1;
               end
               state_in = enter_phase(state_in);
            end
         end else begin
            state_in.tick_count = state_ff.tick_count + TICK_COUNTER_BITS'(1);
         end
      end else if (req_data.cmd_valid) begin
         state_in.active_command = mode_type'(req_data.mode);
         state_in.busy_flag      = 1'b1;
         state_in.phase_index    = 3'd0;
         state_in.bit_index      = 4'd0;
         state_in.address_phase  = 1'b0;
         state_in.tick_count     = TICK_COUNTER_BITS'(1);
         case (mode_type'(req_data.mode))
            MODE_WRITE: state_in.shift_byte = req_data.data_byte;
            MODE_ADDR:  state_in.shift_byte = {req_data.data_byte[6:0], ~req_data.write_request};
            MODE_READ:  state_in.shift_byte = 8'd0;
            default:    ;
         endcase
         state_in = enter_phase(state_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StateReset;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PhaseTicksReset;
      end else if (csr_wr_en) begin
         phase_ticks_ff <= csr_wr_data;
      end
   end

   assign rsp_data.scl_level = state_in.scl_reg;
   assign rsp_data.sda_level = state_in.sda_reg;
   assign rsp_data.sda_drive = state_in.sda_drive_reg;
   assign rsp_data.busy_res  = state_in.busy_flag;
   assign rsp_data.done_res  = done_flag;
   assign rsp_data.read_byte = state_in.read_hold;
   assign rsp_data.ack_seen  = state_in.ack_reg;

   a_idle_count_clear: assert property (@(posedge clock) disable iff (reset)
      !state_ff.busy_flag |-> state_ff.tick_count == '0)
      else $error("tick count not cleared while idle");

   a_busy_count_live: assert property (@(posedge clock) disable iff (reset)
      state_ff.busy_flag |-> state_ff.tick_count != '0)
      else $error("tick count zero while busy");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase_index <= 3'd3)
      else $error("phase index out of range");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.bit_index <= BitsPerByte)
      else $error("bit index out of range");

endmodule

`default_nettype wire

[hdl/i2cm_rsp_skid.sv]
`default_nettype none

module i2cm_rsp_skid (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  i2cm_pkg::rsp_payload_type in_data,
   i2cm_chan_if.source               rsp_chan
);
   import i2cm_pkg::*;

   logic            out_valid_ff, skid_valid_ff;
   rsp_payload_type out_data_ff, skid_data_ff;
   logic            in_fire, out_free;

   assign in_ready = !skid_valid_ff;
   assign in_fire  = in_valid && in_ready;
   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || in_fire;
         skid_valid_ff <= 1'b0;
      end else if (in_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (in_fire) begin
            out_data_ff <= in_data;
         end
      end else if (in_fire) begin
         skid_data_ff <= in_data;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      in_fire && out_valid_ff && !rsp_chan.ready |=> skid_valid_ff)
      else $error("stalled transfer not captured");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_chan.ready |=> !skid_valid_ff)
      else $error("skid entry not drained");

endmodule

`default_nettype wire

[hdl/i2c_master_bit_sequencer_top.sv]
// I2C master bit sequencer.
// req_chan carries one tick per transfer: the sampled SDA level and, while
// the sequencer is idle, an optional command (start, stop, write byte, read
// byte, ACK, NACK, get ACK, address request). Commands seen while busy drop.
// rsp_chan returns one transfer per accepted tick with the SCL level, the SDA
// level and drive enable, busy, done, the last read byte and the ACK flag.
// csr_wr_en / csr_wr_data set the ticks per SCL phase; write only while idle.
// The response to an accepted tick is registered in the output register, or
// in the skid register while the receiver stalls. One tick per cycle is
// accepted while req_chan.ready is high, each updating the sequencer state.
// Reset: bus idle high with SDA driven, no command active, phase length 25.
// When the receiver stalls, a two-entry output buffer holds responses;
// req_chan.ready drops only once both entries are full and rises again once
// rsp_chan takes one and the skid register drains.
`default_nettype none

module i2c_master_bit_sequencer_top #(
   parameter int unsigned TICK_COUNTER_BITS = i2cm_pkg::TickCounterBits
) (
   input  logic        clock,
   input  logic        reset,
   i2cm_chan_if.sink   req_chan,
   i2cm_chan_if.source rsp_chan,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import i2cm_pkg::*;

   logic            step;
   logic            core_ready;
   rsp_payload_type core_rsp;

   assign step           = req_chan.valid && core_ready;
   assign req_chan.ready = core_ready;

   i2cm_seq_core #(
      .TICK_COUNTER_BITS(TICK_COUNTER_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .req_data   (req_chan.payload),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .rsp_data   (core_rsp)
   );

   i2cm_rsp_skid u_skid (
      .clock   (clock),
      .reset   (reset),
      .in_valid(req_chan.valid),
      .in_ready(core_ready),
      .in_data (core_rsp),
      .rsp_chan(rsp_chan)
   );

endmodule

`default_nettype wire
